// ===== rtl/core/mmab_pkg.sv =====
package mmab_pkg;

  // Number of motions and code widths.
  localparam int unsigned NUM_MOTIONS = 11;
  localparam int unsigned MOT_W       = 4;
  localparam int unsigned IDX_W       = $clog2(NUM_MOTIONS);

  // Q16 weights: 65536 is 1.0 and needs 17 bits.
  localparam int unsigned Q_FRAC = 16;
  localparam int unsigned Q_W    = 17;
  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

  // A ramped weight can reach one plus a full step, so it needs one bit more.
  localparam int unsigned W_W   = 18;
  localparam int unsigned SUM_W = W_W + IDX_W;
  localparam int unsigned NUM_W = SUM_W + Q_W;
  localparam int unsigned DIV_CNT_W = $clog2(Q_W);

  // Configuration register widths and indexes.
  localparam int unsigned STEP_W    = 17;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP = 2'd2;

  // Stream widths.
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // Motion codes.
  localparam logic [MOT_W-1:0] M_DEAD      = 4'd0;
  localparam logic [MOT_W-1:0] M_STAND     = 4'd1;
  localparam logic [MOT_W-1:0] M_WALK      = 4'd2;
  localparam logic [MOT_W-1:0] M_KICK      = 4'd3;
  localparam logic [MOT_W-1:0] M_PENALIZED = 4'd4;
  localparam logic [MOT_W-1:0] M_JUMP      = 4'd5;
  localparam logic [MOT_W-1:0] M_STAND_UP  = 4'd6;
  localparam logic [MOT_W-1:0] M_HOLD      = 4'd7;
  localparam logic [MOT_W-1:0] M_SIT_UP    = 4'd8;
  localparam logic [MOT_W-1:0] M_SIT_DOWN  = 4'd9;
  localparam logic [MOT_W-1:0] M_FALL      = 4'd10;

  // Divider request and response.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/mmab_div.sv =====
// Restoring divider, one quotient bit per cycle. The numerator must be below
// den * 2^Q_W so that the quotient fits in Q_W bits.
module mmab_div import mmab_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SUM_W-1:0]     rem_q;
  logic [SUM_W-1:0]     den_q;
  logic [Q_W-1:0]       low_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [SUM_W:0]       trial;
  logic [SUM_W:0]       diff;
  logic                 ge;

  // Trial subtract of the divisor from the shifted partial remainder.
  assign trial = {rem_q, low_q[Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      low_q  <= '0;
      den_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      rem_q  <= req_i.num[NUM_W-1:Q_W];
      low_q  <= req_i.num[Q_W-1:0];
      den_q  <= req_i.den;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
      low_q <= {low_q[Q_W-2:0], ge};
      if (cnt_q == DIV_CNT_W'(Q_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

  // A new division is never started on top of a running one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/motion_mode_arbiter_blend_core.sv =====
// Motion arbiter with blend weights. Each accepted request is one control tick: the
// block picks the active motion (a fall always wins, sit down leaves only through
// sit up, others hand over when their exit flag allows), ramps the per-motion Q16
// weights and the head weight, then normalizes the weights to sum to one and emits
// one result per motion, motion 0 first and the last one marked with tlast. Each
// weight passes through a divider start state, the division run and an emit state,
// which waits while the output is stalled; the shared divider produces one quotient
// bit per cycle, and it is skipped when the ramped weights are all zero. The block
// accepts no request while a tick is in progress, but takes the next one while the
// final result of the previous tick still waits in the output register.
module motion_mode_arbiter_blend_core import mmab_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // From bit 0: fall_wants, fallen, sit_down_exit, walk_exit, kick_exit, jump_exit,
  // stand_up_exit, sit_up_exit, requested_motion[3:0], head_requested, now_ms[31:0].
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // From bit 0: active_motion[3:0], start_blend, weight[16:0], head_weight[16:0].
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // motion_index[3:0].
  output logic [MOT_W-1:0]       m_axis_tuser,
  output logic                   m_axis_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAMP,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [WAIT_W-1:0] fall_wait_q;
  logic [STEP_W-1:0] slow_step_q;
  logic [STEP_W-1:0] fast_step_q;
  logic [MOT_W-1:0]  motion_q;
  logic              start_q;
  logic              fall_active_q;
  logic [TIME_W-1:0] fall_end_q;
  logic [Q_W-1:0]    head_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  sum_q;
  logic [IDX_W-1:0]  idx_q;
  logic [W_W-1:0]    wgt_q [NUM_MOTIONS];
  logic              out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [MOT_W-1:0]  out_user_q;
  logic              out_last_q;

  // Request fields.
  logic              fall_wants;
  logic              fallen;
  logic              sit_down_exit;
  logic              walk_exit;
  logic              kick_exit;
  logic              jump_exit;
  logic              stand_up_exit;
  logic              sit_up_exit;
  logic [MOT_W-1:0]  req_motion;
  logic              head_req;
  logic [TIME_W-1:0] now_ms;

  assign fall_wants    = s_axis_tdata[0];
  assign fallen        = s_axis_tdata[1];
  assign sit_down_exit = s_axis_tdata[2];
  assign walk_exit     = s_axis_tdata[3];
  assign kick_exit     = s_axis_tdata[4];
  assign jump_exit     = s_axis_tdata[5];
  assign stand_up_exit = s_axis_tdata[6];
  assign sit_up_exit   = s_axis_tdata[7];
  assign req_motion    = s_axis_tdata[11:8];
  assign head_req      = s_axis_tdata[12];
  assign now_ms        = s_axis_tdata[44:13];

  logic              accept;
  logic [TIME_W-1:0] elapsed;
  logic              may_leave;
  logic              req_valid;
  logic [MOT_W-1:0]  motion_d;
  logic              start_d;
  logic              fall_active_d;
  logic [TIME_W-1:0] fall_end_d;
  logic [STEP_W-1:0] step_d;
  logic [Q_W:0]      head_sum;
  logic [Q_W-1:0]    head_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign elapsed       = now_ms - fall_end_q;
  assign req_valid     = {1'b0, req_motion} < (MOT_W + 1)'(NUM_MOTIONS);

  // Whether the current motion may be handed over.
  always_comb begin
    case (motion_q)
      M_FALL:                                may_leave = elapsed > TIME_W'(fall_wait_q);
      M_DEAD, M_STAND, M_PENALIZED, M_HOLD:  may_leave = 1'b1;
      M_WALK:                                may_leave = walk_exit;
      M_KICK:                                may_leave = kick_exit;
      M_JUMP:                                may_leave = jump_exit;
      M_STAND_UP:                            may_leave = stand_up_exit;
      M_SIT_UP:                              may_leave = sit_up_exit;
      default:                               may_leave = 1'b0;
    endcase
  end

  // Arbitration in priority order.
  always_comb begin
    motion_d      = motion_q;
    start_d       = 1'b0;
    fall_active_d = fall_active_q;
    fall_end_d    = fall_end_q;
    if (fall_wants) begin
      fall_active_d = 1'b1;
      motion_d      = M_FALL;
    end else if (fallen && fall_active_q) begin
      fall_active_d = 1'b0;
      fall_end_d    = now_ms;
    end else if (motion_q == M_SIT_DOWN) begin
      if (sit_down_exit && req_motion != M_SIT_DOWN) begin
        motion_d = M_SIT_UP;
      end
    end else if (may_leave && req_valid) begin
      motion_d = req_motion;
      start_d  = 1'b1;
    end
  end

  // Fast ramp for the abrupt motions.
  always_comb begin
    if (motion_d inside {M_FALL, M_STAND_UP, M_KICK, M_JUMP, M_SIT_UP}) begin
      step_d = fast_step_q;
    end else begin
      step_d = slow_step_q;
    end
  end

  // Head weight ramps up toward one or down toward zero.
  assign head_sum = {1'b0, head_q} + {1'b0, step_d};
  always_comb begin
    if (head_req && !fallen) begin
      head_d = (head_sum > {1'b0, Q_ONE}) ? Q_ONE : head_sum[Q_W-1:0];
    end else begin
      head_d = (head_q > step_d) ? head_q - step_d : '0;
    end
  end

  // Ramp of the weight under the index counter.
  logic [W_W-1:0] w_cur;
  logic [W_W-1:0] w_step;
  logic [W_W-1:0] w_ramp;
  logic           idx_last;

  assign w_cur    = wgt_q[idx_q];
  assign w_step   = W_W'(step_q);
  assign idx_last = (idx_q == IDX_W'(NUM_MOTIONS - 1));

  always_comb begin
    if (MOT_W'(idx_q) == motion_q) begin
      w_ramp = w_cur + w_step;
    end else begin
      w_ramp = (w_cur > w_step) ? w_cur - w_step : '0;
    end
  end

  // Normalization: round(w * 65536 / sum) through the shared divider.
  div_req_t       div_req;
  div_rsp_t       div_rsp;
  logic           sum_zero;
  logic [Q_W-1:0] norm;

  assign sum_zero      = (sum_q == '0);
  assign div_req.start = (state_q == ST_DIV_START) && !sum_zero;
  assign div_req.num   = (NUM_W'(w_cur) << Q_FRAC) + NUM_W'(sum_q >> 1);
  assign div_req.den   = sum_q;
  assign norm          = sum_zero ? '0 : div_rsp.quot;

  mmab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The output register takes a new result when it is empty or being drained.
  logic out_free;
  logic emit_fire;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign emit_fire = (state_q == ST_EMIT) && out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_wait_q <= WAIT_W'(1000);
      slow_step_q <= STEP_W'(655);
      fast_step_q <= STEP_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FALL_WAIT: fall_wait_q <= cfg_wdata_i[WAIT_W-1:0];
        CFG_SLOW_STEP: slow_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_FAST_STEP: fast_step_q <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, tick state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      motion_q      <= M_DEAD;
      start_q       <= 1'b0;
      fall_active_q <= 1'b0;
      fall_end_q    <= '0;
      head_q        <= '0;
      step_q        <= '0;
      sum_q         <= '0;
      idx_q         <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_user_q    <= '0;
      out_last_q    <= 1'b0;
      for (int i = 0; i < NUM_MOTIONS; i++) begin
        wgt_q[i] <= (i == 0) ? W_W'(Q_ONE) : '0;
      end
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            motion_q      <= motion_d;
            start_q       <= start_d;
            fall_active_q <= fall_active_d;
            fall_end_q    <= fall_end_d;
            head_q        <= head_d;
            step_q        <= step_d;
            sum_q         <= '0;
            idx_q         <= '0;
            state_q       <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          wgt_q[idx_q] <= w_ramp;
          sum_q        <= sum_q + SUM_W'(w_ramp);
          if (idx_last) begin
            idx_q   <= '0;
            state_q <= ST_DIV_START;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DIV_START: begin
          state_q <= sum_zero ? ST_EMIT : ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (div_rsp.done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            wgt_q[idx_q] <= W_W'(norm);
            out_data_q   <= {1'b0, head_q, norm, start_q, motion_q};
            out_user_q   <= MOT_W'(idx_q);
            out_last_q   <= idx_last;
            if (idx_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_DIV_START;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // A fall request always makes fall the active motion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fall_wants |=> motion_q == M_FALL && fall_active_q)
    else $error("fall request did not take priority");

  // The head weight never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) head_q <= Q_ONE)
    else $error("head weight above one");

  // The marked result belongs to the last motion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == MOT_W'(NUM_MOTIONS - 1))
    else $error("last marker on wrong motion");

endmodule
